FILE: hw/rtl/sfdm_pkg.sv
// Shared types and constants for the stereo feedback delay mixer.
package sfdm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STORE_W = 20;
  localparam int GAIN_W = 17;
  localparam int DELAY_W = 17;
  localparam int DATA_W = 2 * SAMPLE_W;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd2;

  localparam logic [GAIN_W-1:0] Q15_ONE = 17'd32768;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd1;

  // Output queue; its depth also bounds the items in flight.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW = 3;
  localparam int FIFO_CW = 4;
  localparam logic [FIFO_CW-1:0] FIFO_FULL = 4'd8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [STORE_W-1:0] store_word_t;

  // Per-cycle control that the top level hands to each channel lane.
  typedef struct packed {
    logic accept;
    logic b_valid;
    logic clear;
  } lane_ctl_t;

endpackage

FILE: hw/rtl/sfdm_lane.sv
// One channel of the echo: delay store, feedback write-back and wet/dry mix.
module sfdm_lane #(
  parameter int STORE_FRAMES = 65536,
  parameter int AW = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  sfdm_pkg::lane_ctl_t     ctl,
  input  logic [AW-1:0]           rd_addr,
  input  logic [AW-1:0]           wr_addr,
  input  logic [AW-1:0]           clr_addr,
  input  sfdm_pkg::sample_t       dry,
  input  logic [sfdm_pkg::GAIN_W-1:0] wet,
  input  logic signed [15:0]      feedback,
  output sfdm_pkg::sample_t       sample
);
  import sfdm_pkg::*;

  function automatic store_word_t sat_store(input logic signed [21:0] v);
    if (v > 22'sd524287) begin
      return 20'sd524287;
    end else if (v < -22'sd524288) begin
      return -20'sd524288;
    end
    return v[19:0];
  endfunction

  function automatic sample_t sat_sample(input logic signed [23:0] v);
    if (v > 24'sd32767) begin
      return 16'sd32767;
    end else if (v < -24'sd32768) begin
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  store_word_t mem [STORE_FRAMES];
  store_word_t rd_q;

  logic              wr_en;
  logic [AW-1:0]     wr_a;
  store_word_t       wr_d;

  logic              fwd_en;
  logic [AW-1:0]     fwd_addr;
  store_word_t       fwd_data;

  sample_t           b_dry;
  logic [AW-1:0]     b_rp;
  logic [AW-1:0]     b_wp;
  logic              hit;
  store_word_t       delayed;
  logic signed [35:0] fb_prod;
  logic signed [35:0] fb_rnd;
  logic signed [20:0] fb_q;
  logic signed [21:0] fb_sum;
  store_word_t       store_word;

  sample_t           c_dry;
  store_word_t       c_delayed;
  logic [GAIN_W-1:0] dry_w;
  logic signed [33:0] p_dry;
  logic signed [37:0] p_wet;

  logic signed [33:0] d_dry;
  logic signed [37:0] d_wet;
  logic signed [38:0] mix;

  // The clearing sweep owns the write port after reset; then stage B writes.
  assign wr_en = ctl.clear || ctl.b_valid;
  assign wr_a  = ctl.clear ? clr_addr : b_wp;
  assign wr_d  = ctl.clear ? '0 : store_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_a] <= wr_d;
    end
    if (ctl.accept) begin
      rd_q <= mem[rd_addr];
    end
  end

  // The read returns the old word when it meets a write at the same edge,
  // so the write of that edge is kept for a bypass.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_en <= 1'b0;
    end else begin
      fwd_en <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= wr_a;
    fwd_data <= wr_d;
    if (ctl.accept) begin
      b_dry <= dry;
      b_rp  <= rd_addr;
      b_wp  <= wr_addr;
    end
    c_dry     <= b_dry;
    c_delayed <= delayed;
    d_dry     <= p_dry;
    d_wet     <= p_wet;
  end

  // Stage B: the feedback recurrence closes here.
  assign hit        = fwd_en && (fwd_addr == b_rp);
  assign delayed    = hit ? fwd_data : rd_q;
  assign fb_prod    = delayed * feedback;
  assign fb_rnd     = fb_prod + 36'sd16384;
  assign fb_q       = fb_rnd[35:15];
  assign fb_sum     = 22'(b_dry) + 22'(fb_q);
  assign store_word = sat_store(fb_sum);

  // Stage C: the two mix products.
  assign dry_w = Q15_ONE - wet;
  assign p_dry = $signed({1'b0, dry_w}) * c_dry;
  assign p_wet = $signed({1'b0, wet}) * c_delayed;

  // Stage D: sum, round half up and saturate.
  assign mix    = 39'(d_dry) + 39'(d_wet) + 39'sd16384;
  assign sample = sat_sample(mix[38:15]);

endmodule

FILE: hw/rtl/sfdm_out_fifo.sv
// Output queue that merges both channel results into one stream item.
module sfdm_out_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  sfdm_pkg::sample_t            left,
  input  sfdm_pkg::sample_t            right,
  input  logic                         ready,
  output logic                         valid,
  output logic [sfdm_pkg::DATA_W-1:0]  data
);
  import sfdm_pkg::*;

  logic [DATA_W-1:0]  entry [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic               pop;

  assign valid = (count != '0);
  assign pop   = valid && ready;
  assign data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= {right, left};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/stereo_feedback_delay_mix.sv
// Stereo feedback delay mixer: one stereo frame per item, registered through stages B, C and D.
// Throughput is one item per cycle while s_tready is high: each lane does one store read
// and one write per cycle; the feedback path closes through a multiply-add with write bypass.
// Up to 8 items may be accepted and not yet taken; the output queue bounds that count.
// Reset (rst, synchronous) restores the registers and then sweeps the delay store to zero,
// one frame per cycle until every frame is cleared, during which no item is accepted.
module stereo_feedback_delay_mix #(
  parameter int STORE_FRAMES = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [sfdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfdm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sfdm_pkg::DATA_W-1:0]       s_tdata,   // in_left, in_right
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sfdm_pkg::DATA_W-1:0]       m_tdata    // out_left, out_right
);
  import sfdm_pkg::*;

  localparam int AW = (STORE_FRAMES > 1) ? $clog2(STORE_FRAMES) : 1;
  localparam int PW = AW + 1;
  localparam int CW = (PW > DELAY_W) ? PW : DELAY_W;
  localparam logic [CW-1:0] FRAMES_CW = CW'(STORE_FRAMES);
  localparam logic [PW-1:0] FRAMES_PW = PW'(STORE_FRAMES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_FRAMES - 1);

  logic [DELAY_W-1:0]  delay_frames;
  logic [15:0]         wet_gain;
  logic signed [15:0]  feedback_gain;

  logic [AW-1:0]       wp;
  logic                clearing;
  logic [AW-1:0]       clr_addr;
  logic                b_valid;
  logic                c_valid;
  logic                d_valid;
  logic [FIFO_CW-1:0]  credits;

  logic                accept;
  logic                pop;
  sample_t             in_left;
  sample_t             in_right;
  sample_t             out_left;
  sample_t             out_right;
  logic [GAIN_W-1:0]   wet_eff;
  logic [CW-1:0]       delay_ext;
  logic [PW-1:0]       delay_eff;
  logic [PW-1:0]       wp_ext;
  logic [AW-1:0]       rp;
  lane_ctl_t           ctl;

  assign in_left  = s_tdata[15:0];
  assign in_right = s_tdata[31:16];

  assign s_tready = !clearing && (credits != FIFO_FULL);
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  // A delay of zero or beyond the store depth reads the slot about to be overwritten.
  assign delay_ext = CW'(delay_frames);
  assign delay_eff = ((delay_ext == '0) || (delay_ext > FRAMES_CW)) ? FRAMES_PW
                                                                   : PW'(delay_ext);
  assign wp_ext = PW'(wp);
  assign rp = (wp_ext >= delay_eff) ? AW'(wp_ext - delay_eff)
                                    : AW'(wp_ext + FRAMES_PW - delay_eff);

  assign wet_eff = ({1'b0, wet_gain} > Q15_ONE) ? Q15_ONE : {1'b0, wet_gain};

  assign ctl = '{accept: accept, b_valid: b_valid, clear: clearing};

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_frames  <= DELAY_RESET;
      wet_gain      <= '0;
      feedback_gain <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DELAY:    delay_frames  <= cfg_data[DELAY_W-1:0];
        CFG_WET:      wet_gain      <= cfg_data[15:0];
        CFG_FEEDBACK: feedback_gain <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      clearing <= 1'b1;
      clr_addr <= '0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      d_valid  <= 1'b0;
      credits  <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        wp <= (wp == LAST_ADDR) ? '0 : wp + 1'b1;
      end
      b_valid <= accept;
      c_valid <= b_valid;
      d_valid <= c_valid;
      case ({accept, pop})
        2'b10:   credits <= credits + 1'b1;
        2'b01:   credits <= credits - 1'b1;
        default: credits <= credits;
      endcase
    end
  end

  sfdm_lane #(
    .STORE_FRAMES (STORE_FRAMES),
    .AW           (AW)
  ) u_lane_left (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_addr  (rp),
    .wr_addr  (wp),
    .clr_addr (clr_addr),
    .dry      (in_left),
    .wet      (wet_eff),
    .feedback (feedback_gain),
    .sample   (out_left)
  );

  sfdm_lane #(
    .STORE_FRAMES (STORE_FRAMES),
    .AW           (AW)
  ) u_lane_right (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_addr  (rp),
    .wr_addr  (wp),
    .clr_addr (clr_addr),
    .dry      (in_right),
    .wet      (wet_eff),
    .feedback (feedback_gain),
    .sample   (out_right)
  );

  sfdm_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (d_valid),
    .left  (out_left),
    .right (out_right),
    .ready (m_tready),
    .valid (m_tvalid),
    .data  (m_tdata)
  );

  // Every accepted item reaches the output queue through b_valid, c_valid and d_valid.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##2 d_valid)
    else $error("accepted item did not reach the output stage");

  // Items in flight never exceed the queue depth.
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= FIFO_FULL)
    else $error("in-flight count exceeds output queue depth");

  // An item in the last stage always holds a credit.
  a_credit_held: assert property (@(posedge clk) disable iff (rst)
    d_valid |-> (credits != '0))
    else $error("pipeline item without a credit");

  // The read frame index stays inside the store.
  a_rp_range: assert property (@(posedge clk) disable iff (rst)
    accept |-> (PW'(rp) < FRAMES_PW))
    else $error("read index outside the delay store");

endmodule
